FILE: rtl/core/x86_subset_instruction_predecoder_unit_assert.svh
// assertion macros for the predecoder
`ifndef X86_SUBSET_INSTRUCTION_PREDECODER_UNIT_ASSERT_SVH
`define X86_SUBSET_INSTRUCTION_PREDECODER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define XPD_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define XPD_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define XPD_ASSERT_IMP(label, clk, rst, a, c)
`define XPD_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

FILE: rtl/core/xpd_pkg.sv
// ----------------------------------------------------------------------------
// xpd_pkg
// types, constants and decode functions for the predecoder
// ----------------------------------------------------------------------------
package xpd_pkg;

  localparam int MaxBufferBytes = 65536;

  typedef enum logic [2:0] {
    PH_OPCODE    = 3'd0,
    PH_SECOND    = 3'd1,
    PH_AFTER_REP = 3'd2,
    PH_MODRM     = 3'd3,
    PH_SIB       = 3'd4,
    PH_DISP      = 3'd5,
    PH_IMM       = 3'd6
  } phase_t;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_IMM8   = 3'd1;
  localparam logic [2:0] KIND_IMM32  = 3'd2;
  localparam logic [2:0] KIND_TARGET = 3'd3;
  localparam logic [2:0] KIND_ONE    = 3'd4;
  localparam logic [2:0] KIND_CL     = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNKNOWN    = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;

  localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
  localparam logic [7:0] OP_REP      = 8'hF3;
  localparam logic [7:0] OP_GROUP5   = 8'hFF;

  typedef struct packed {
    logic [5:0] mnem;
    logic       has_mr;
    logic [2:0] kind;
    logic [2:0] nbytes;
    logic       regdst;
    logic [3:0] embed;
    logic       unknown;
  } shape_t;

  function automatic shape_t describe(logic [7:0] first, logic [7:0] second,
                                      logic [7:0] mr);
    shape_t s;
    logic [2:0] rf;
    logic [2:0] lo;
    s = '0;
    rf = mr[5:3];
    lo = first[2:0];
    if (first < 8'h40 && lo < 3'd6) begin
      s.mnem = 6'd1 + {3'd0, first[5:3]};
      if (lo < 3'd4) begin
        s.has_mr = 1'b1; s.regdst = first[1];
      end else if (lo == 3'd4) begin
        s.kind = KIND_IMM8; s.nbytes = 3'd1;
      end else begin
        s.kind = KIND_IMM32; s.nbytes = 3'd4;
      end
    end else if (first == OP_TWO_BYTE) begin
      case (second)
        8'hB6: s.mnem = 6'd37;
        8'hB7: s.mnem = 6'd38;
        8'hBE: s.mnem = 6'd39;
        8'hBF: s.mnem = 6'd40;
        default: s.unknown = 1'b1;
      endcase
      if (!s.unknown) begin
        s.has_mr = 1'b1; s.regdst = 1'b1;
      end
    end else if (first == OP_REP) begin
      case (second)
        8'hA4: s.mnem = 6'd58;
        8'hA5: s.mnem = 6'd59;
        default: begin s.mnem = 6'd57; s.unknown = 1'b1; end
      endcase
    end else if (first >= 8'h40 && first <= 8'h5F) begin
      s.mnem = 6'd10 + {4'd0, first[4:3]};
      s.embed = {1'b0, lo};
    end else if (first >= 8'h70 && first <= 8'h7F) begin
      s.mnem = 6'd14; s.kind = KIND_IMM8; s.nbytes = 3'd1; s.embed = first[3:0];
    end else if (first >= 8'hB0 && first <= 8'hBF) begin
      s.mnem = 6'd9; s.embed = {1'b0, lo};
      if (!first[3]) begin
        s.kind = KIND_IMM8; s.nbytes = 3'd1;
      end else begin
        s.kind = KIND_IMM32; s.nbytes = 3'd4;
      end
    end else if (first >= 8'hA4 && first <= 8'hA7) begin
      s.mnem = 6'd45 + {4'd0, first[1:0]};
    end else if (first >= 8'hAA && first <= 8'hAF) begin
      s.mnem = 6'd49 + {2'd0, first[3:0] - 4'hA};
    end else begin
      case (first)
        8'h88, 8'h89, 8'h8A, 8'h8B: begin
          s.mnem = 6'd9; s.has_mr = 1'b1; s.regdst = first[1];
        end
        8'h8D: begin s.mnem = 6'd20; s.has_mr = 1'b1; s.regdst = 1'b1; end
        8'h84, 8'h85: begin s.mnem = 6'd21; s.has_mr = 1'b1; end
        8'h86, 8'h87: begin s.mnem = 6'd22; s.has_mr = 1'b1; end
        8'h80, 8'h83: begin
          s.mnem = 6'd1 + {3'd0, rf}; s.has_mr = 1'b1;
          s.kind = KIND_IMM8; s.nbytes = 3'd1;
        end
        8'h81: begin
          s.mnem = 6'd1 + {3'd0, rf}; s.has_mr = 1'b1;
          s.kind = KIND_IMM32; s.nbytes = 3'd4;
        end
        8'hC6: begin s.mnem = 6'd9; s.has_mr = 1'b1; s.kind = KIND_IMM8; s.nbytes = 3'd1; end
        8'hC7: begin s.mnem = 6'd9; s.has_mr = 1'b1; s.kind = KIND_IMM32; s.nbytes = 3'd4; end
        8'hC0, 8'hC1: begin
          s.mnem = 6'd23 + {3'd0, rf}; s.has_mr = 1'b1;
          s.kind = KIND_IMM8; s.nbytes = 3'd1;
        end
        8'hD0, 8'hD1: begin s.mnem = 6'd23 + {3'd0, rf}; s.has_mr = 1'b1; s.kind = KIND_ONE; end
        8'hD2, 8'hD3: begin s.mnem = 6'd23 + {3'd0, rf}; s.has_mr = 1'b1; s.kind = KIND_CL; end
        8'hF6, 8'hF7: begin
          s.has_mr = 1'b1;
          if (rf < 3'd2) begin
            s.mnem = 6'd21;
            if (!first[0]) begin
              s.kind = KIND_IMM8; s.nbytes = 3'd1;
            end else begin
              s.kind = KIND_IMM32; s.nbytes = 3'd4;
            end
          end else begin
            s.mnem = 6'd29 + {3'd0, rf};
          end
        end
        8'hFF: begin
          s.has_mr = 1'b1;
          case (rf)
            3'd0: s.mnem = 6'd10;
            3'd1: s.mnem = 6'd11;
            3'd2: s.mnem = 6'd15;
            3'd4: s.mnem = 6'd16;
            default: s.unknown = 1'b1;
          endcase
        end
        8'h68: begin s.mnem = 6'd12; s.kind = KIND_IMM32; s.nbytes = 3'd4; end
        8'h6A: begin s.mnem = 6'd12; s.kind = KIND_IMM8; s.nbytes = 3'd1; end
        8'h90: s.mnem = 6'd17;
        8'hC3: s.mnem = 6'd18;
        8'hCC: s.mnem = 6'd19;
        8'hE0: begin s.mnem = 6'd41; s.kind = KIND_IMM8; s.nbytes = 3'd1; end
        8'hE1: begin s.mnem = 6'd42; s.kind = KIND_IMM8; s.nbytes = 3'd1; end
        8'hE2: begin s.mnem = 6'd43; s.kind = KIND_TARGET; s.nbytes = 3'd1; end
        8'hE3: begin s.mnem = 6'd44; s.kind = KIND_IMM8; s.nbytes = 3'd1; end
        8'hE8: begin s.mnem = 6'd15; s.kind = KIND_TARGET; s.nbytes = 3'd4; end
        8'hE9: begin s.mnem = 6'd16; s.kind = KIND_TARGET; s.nbytes = 3'd4; end
        8'hEB: begin s.mnem = 6'd16; s.kind = KIND_IMM8; s.nbytes = 3'd1; end
        8'hF0: s.mnem = 6'd55;
        8'hF2: s.mnem = 6'd56;
        default: s.unknown = 1'b1;
      endcase
    end
    return s;
  endfunction

  function automatic logic sib_present(logic [7:0] mr);
    return (mr[7:6] != 2'd3) && (mr[2:0] == 3'd4);
  endfunction

  function automatic logic [2:0] disp_bytes(logic [7:0] mr, logic [7:0] sib);
    logic [2:0] d;
    case (mr[7:6])
      2'd3: d = 3'd0;
      2'd1: d = 3'd1;
      2'd2: d = 3'd4;
      default: begin
        if (mr[2:0] == 3'd5) d = 3'd4;
        else if (mr[2:0] == 3'd4 && sib[2:0] == 3'd5) d = 3'd4;
        else d = 3'd0;
      end
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/x86_subset_instruction_predecoder_unit.sv
// ----------------------------------------------------------------------------
// x86_subset_instruction_predecoder_unit
// byte-serial x86 predecoder: assembles instructions and emits one result each
// ----------------------------------------------------------------------------
// result: registered on the edge that accepts the byte that completes it
// throughput: one code byte per cycle while no unread result is held, set by
//   the single-pass parse logic between the parse state and the result register
// reset: synchronous; parse state returns to opcode fetch at offset zero
`include "x86_subset_instruction_predecoder_unit_assert.svh"
module x86_subset_instruction_predecoder_unit #(
  parameter int MAX_BUFFER_BYTES = xpd_pkg::MaxBufferBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] start_offset,
  output logic [5:0]  mnemonic,
  output logic [3:0]  length,
  output logic [7:0]  modrm_byte,
  output logic [7:0]  sib_byte,
  output logic signed [31:0] displacement,
  output logic [31:0] immediate,
  output logic [4:0]  operand_layout,
  output logic        reg_is_destination,
  output logic [3:0]  embedded_field,
  output logic [1:0]  status,
  output logic        last_of_run
);
  import xpd_pkg::*;

  localparam int OffW = $clog2(MAX_BUFFER_BYTES);

  phase_t      phase, phase_next;
  logic [7:0]  h_op, h_op_next, h_op2, h_op2_next, h_mr, h_mr_next, h_sib, h_sib_next;
  logic [31:0] disp_acc, disp_acc_next, imm_acc, imm_acc_next;
  logic [2:0]  left, left_next;
  logic [OffW-1:0] cur_off, inst_start, inst_start_next;
  logic [3:0]  bcount, bcount_next;

  logic        accept, emit;
  logic [2:0]  idx;
  shape_t      s_now, s_fin;
  shape_t      s_now_out;
  logic        done, need_disp, need_imm, eob_flush;
  logic [1:0]  st;
  logic [2:0]  ds;
  logic [31:0] dv, iv, sx;
  logic [15:0] start16;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next = phase;
    h_op_next = h_op; h_op2_next = h_op2; h_mr_next = h_mr; h_sib_next = h_sib;
    disp_acc_next = disp_acc; imm_acc_next = imm_acc; left_next = left;
    inst_start_next = inst_start; bcount_next = bcount;
    done = 1'b0; need_disp = 1'b0; need_imm = 1'b0; st = ST_OK;
    idx = 3'd0;
    s_now = '0;
    if (phase == PH_OPCODE) begin
      inst_start_next = cur_off;
      bcount_next = 4'd1;
      h_op_next = code_byte; h_op2_next = '0; h_mr_next = '0; h_sib_next = '0;
      disp_acc_next = '0; imm_acc_next = '0; left_next = '0;
      if (code_byte == OP_TWO_BYTE) phase_next = PH_SECOND;
      else if (code_byte == OP_REP) phase_next = PH_AFTER_REP;
      else begin
        s_now = describe(code_byte, 8'd0, 8'd0);
        if (s_now.unknown) begin done = 1'b1; st = ST_UNKNOWN; end
        else if (s_now.has_mr) phase_next = PH_MODRM;
        else need_imm = 1'b1;
      end
    end else begin
      bcount_next = bcount + 4'd1;
      case (phase)
        PH_SECOND: begin
          h_op2_next = code_byte;
          s_now = describe(h_op, code_byte, 8'd0);
          if (!s_now.unknown) phase_next = PH_MODRM;
          else if (!end_of_buffer) begin done = 1'b1; st = ST_UNKNOWN; end
        end
        PH_AFTER_REP: begin
          h_op2_next = code_byte;
          s_now = describe(h_op, code_byte, 8'd0);
          done = 1'b1;
          st = s_now.unknown ? ST_UNKNOWN : ST_OK;
        end
        PH_MODRM: begin
          h_mr_next = code_byte;
          s_now = describe(h_op, h_op2, code_byte);
          if (s_now.unknown) begin done = 1'b1; st = ST_UNKNOWN; end
          else if (sib_present(code_byte)) phase_next = PH_SIB;
          else need_disp = 1'b1;
        end
        PH_SIB: begin
          h_sib_next = code_byte;
          need_disp = 1'b1;
        end
        PH_DISP: begin
          idx = disp_bytes(h_mr, h_sib) - left;
          disp_acc_next = disp_acc | ({24'd0, code_byte} << {idx[1:0], 3'd0});
          left_next = left - 3'd1;
          if (left_next == 3'd0) need_imm = 1'b1;
        end
        default: begin
          s_now = describe(h_op, h_op2, h_mr);
          idx = s_now.nbytes - left;
          imm_acc_next = imm_acc | ({24'd0, code_byte} << {idx[1:0], 3'd0});
          left_next = left - 3'd1;
          if (left_next == 3'd0) done = 1'b1;
        end
      endcase
    end
    if (need_disp) begin
      if (disp_bytes(h_mr_next, h_sib_next) != 3'd0) begin
        left_next = disp_bytes(h_mr_next, h_sib_next);
        phase_next = PH_DISP;
      end else need_imm = 1'b1;
    end
    s_fin = describe(h_op_next, h_op2_next, h_mr_next);
    if (need_imm) begin
      if (s_fin.nbytes != 3'd0) begin
        left_next = s_fin.nbytes;
        phase_next = PH_IMM;
      end else done = 1'b1;
    end
    eob_flush = !done && end_of_buffer && (phase_next != PH_OPCODE);
    if (done || eob_flush) phase_next = PH_OPCODE;
  end

  assign emit = done || eob_flush;

  // result fields from the completed instruction state
  always_comb begin
    shape_t f;
    f = s_fin;
    if (h_op_next == OP_TWO_BYTE && f.unknown) f.has_mr = 1'b0;
    if (st == ST_UNKNOWN && h_op_next != OP_REP && h_op_next != OP_GROUP5) f.mnem = '0;
    ds = 3'd0;
    if (f.has_mr && !f.unknown) ds = disp_bytes(h_mr_next, h_sib_next);
    sx = {{24{imm_acc_next[7]}}, imm_acc_next[7:0]};
    dv = (ds == 3'd1) ? {{24{disp_acc_next[7]}}, disp_acc_next[7:0]} :
         (ds == 3'd4) ? disp_acc_next : 32'd0;
    start16 = 16'(inst_start_next);
    iv = imm_acc_next;
    if (f.kind == KIND_TARGET) begin
      if (f.nbytes == 3'd4) iv = 32'(inst_start_next) + 32'd5 + imm_acc_next;
      else iv = 32'(inst_start_next) + 32'd2 + sx;
    end
    s_now_out = f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OPCODE;
      cur_off <= '0;
      out_valid <= 1'b0;
      h_op <= '0; h_op2 <= '0; h_mr <= '0; h_sib <= '0;
      disp_acc <= '0; imm_acc <= '0; left <= '0;
      inst_start <= '0; bcount <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (accept) begin
        phase <= phase_next;
        h_op <= h_op_next; h_op2 <= h_op2_next; h_mr <= h_mr_next; h_sib <= h_sib_next;
        disp_acc <= disp_acc_next; imm_acc <= imm_acc_next; left <= left_next;
        inst_start <= inst_start_next; bcount <= bcount_next;
        // offsets wrap at the buffer size and restart at zero after end_of_buffer
        if (end_of_buffer || cur_off == OffW'(MAX_BUFFER_BYTES - 1)) cur_off <= '0;
        else cur_off <= cur_off + 1'b1;
        if (emit) out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      start_offset <= start16;
      length <= bcount_next;
      last_of_run <= 1'b1;
      if (done) begin
        mnemonic <= s_now_out.mnem;
        modrm_byte <= s_now_out.has_mr ? h_mr_next : 8'd0;
        sib_byte <= (s_now_out.has_mr && !s_now_out.unknown && sib_present(h_mr_next))
                    ? h_sib_next : 8'd0;
        displacement <= dv;
        immediate <= iv;
        operand_layout <= (ds == 3'd0) ? {2'd0, s_now_out.kind} :
                          (ds == 3'd1) ? 5'd6 + {2'd0, s_now_out.kind} :
                                         5'd12 + {2'd0, s_now_out.kind};
        reg_is_destination <= s_now_out.regdst;
        embedded_field <= s_now_out.embed;
        status <= st;
      end else begin
        mnemonic <= '0; modrm_byte <= '0; sib_byte <= '0; displacement <= '0;
        immediate <= '0; operand_layout <= '0; reg_is_destination <= 1'b0;
        embedded_field <= '0; status <= ST_INCOMPLETE;
      end
    end
  end

  `XPD_ASSERT_NXT(a_emit_valid, clk, rst, accept && emit, out_valid)
  `XPD_ASSERT_NXT(a_idle_after_emit, clk, rst, accept && emit, phase == PH_OPCODE)
  `XPD_ASSERT_IMP(a_ready, clk, rst, !out_valid, in_ready)
  `XPD_ASSERT_NXT(a_eob_off, clk, rst, accept && end_of_buffer, cur_off == '0)

endmodule

FILE: test/x86_subset_instruction_predecoder_unit_checker.sv
// ----------------------------------------------------------------------------
// x86 predecoder checker
// watches both channels, predicts each decoded instruction from the accepted
// code bytes and compares every result field against the oldest prediction
// ----------------------------------------------------------------------------
module x86_subset_instruction_predecoder_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  code_byte,
  input  logic        end_of_buffer,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] start_offset,
  input  logic [5:0]  mnemonic,
  input  logic [3:0]  length,
  input  logic [7:0]  modrm_byte,
  input  logic [7:0]  sib_byte,
  input  logic signed [31:0] displacement,
  input  logic [31:0] immediate,
  input  logic [4:0]  operand_layout,
  input  logic        reg_is_destination,
  input  logic [3:0]  embedded_field,
  input  logic [1:0]  status,
  input  logic        last_of_run,
  output int          fail_count,
  output int          pending,
  output int          insn_count,
  output int          bad_count,
  output int          trunc_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import xpd_pkg::*;

  typedef struct packed {
    logic [15:0] start;
    logic [5:0]  mnem;
    logic [3:0]  len;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [31:0] disp;
    logic [31:0] imm;
    logic [4:0]  layout;
    logic        regdst;
    logic [3:0]  embed;
    logic [1:0]  st;
    logic        last;
  } insn_t;

  insn_t insn_q[$];

  // decoder state
  phase_t      phase;
  logic [7:0]  op1, op2, mr, sb;
  logic [31:0] dacc, iacc;
  logic [2:0]  left;
  logic [15:0] offs, istart;
  logic [3:0]  nbytes_taken;

  typedef struct {
    logic [5:0] mnem;
    logic       has_mr;
    logic [2:0] kind;
    logic [2:0] nb;
    logic       regdst;
    logic [3:0] embed;
    logic       unk;
  } form_t;

  function automatic form_t classify(logic [7:0] f, logic [7:0] s2, logic [7:0] m);
    form_t r;
    logic [2:0] rf;
    r = '{default: '0};
    rf = m[5:3];
    if (f < 8'h40 && f[2:0] < 3'd6) begin
      r.mnem = 6'd1 + f[5:3];
      if (f[2:0] < 3'd4) begin r.has_mr = 1; r.regdst = f[1]; end
      else if (f[2:0] == 3'd4) begin r.kind = KIND_IMM8; r.nb = 1; end
      else begin r.kind = KIND_IMM32; r.nb = 4; end
    end else if (f == OP_TWO_BYTE) begin
      if (s2 == 8'hB6) r.mnem = 37;
      else if (s2 == 8'hB7) r.mnem = 38;
      else if (s2 == 8'hBE) r.mnem = 39;
      else if (s2 == 8'hBF) r.mnem = 40;
      else r.unk = 1;
      if (!r.unk) begin r.has_mr = 1; r.regdst = 1; end
    end else if (f == OP_REP) begin
      if (s2 == 8'hA4) r.mnem = 58;
      else if (s2 == 8'hA5) r.mnem = 59;
      else begin r.mnem = 57; r.unk = 1; end
    end else if (f >= 8'h40 && f <= 8'h5F) begin
      r.mnem = 6'd10 + ((f - 8'h40) >> 3); r.embed = f[2:0];
    end else if (f >= 8'h70 && f <= 8'h7F) begin
      r.mnem = 14; r.kind = KIND_IMM8; r.nb = 1; r.embed = f[3:0];
    end else if (f >= 8'hB0 && f <= 8'hBF) begin
      r.mnem = 9; r.embed = f[2:0];
      if (f < 8'hB8) begin r.kind = KIND_IMM8; r.nb = 1; end
      else begin r.kind = KIND_IMM32; r.nb = 4; end
    end else if (f >= 8'hA4 && f <= 8'hA7) r.mnem = 6'd45 + (f - 8'hA4);
    else if (f >= 8'hAA && f <= 8'hAF) r.mnem = 6'd49 + (f - 8'hAA);
    else begin
      case (f)
        8'h88, 8'h89, 8'h8A, 8'h8B: begin r.mnem = 9; r.has_mr = 1; r.regdst = f[1]; end
        8'h8D: begin r.mnem = 20; r.has_mr = 1; r.regdst = 1; end
        8'h84, 8'h85: begin r.mnem = 21; r.has_mr = 1; end
        8'h86, 8'h87: begin r.mnem = 22; r.has_mr = 1; end
        8'h80, 8'h83: begin r.mnem = 6'd1 + rf; r.has_mr = 1; r.kind = KIND_IMM8; r.nb = 1; end
        8'h81: begin r.mnem = 6'd1 + rf; r.has_mr = 1; r.kind = KIND_IMM32; r.nb = 4; end
        8'hC6: begin r.mnem = 9; r.has_mr = 1; r.kind = KIND_IMM8; r.nb = 1; end
        8'hC7: begin r.mnem = 9; r.has_mr = 1; r.kind = KIND_IMM32; r.nb = 4; end
        8'hC0, 8'hC1: begin r.mnem = 6'd23 + rf; r.has_mr = 1; r.kind = KIND_IMM8; r.nb = 1; end
        8'hD0, 8'hD1: begin r.mnem = 6'd23 + rf; r.has_mr = 1; r.kind = KIND_ONE; end
        8'hD2, 8'hD3: begin r.mnem = 6'd23 + rf; r.has_mr = 1; r.kind = KIND_CL; end
        8'hF6, 8'hF7: begin
          r.has_mr = 1;
          if (rf < 2) begin
            r.mnem = 21;
            if (f == 8'hF6) begin r.kind = KIND_IMM8; r.nb = 1; end
            else begin r.kind = KIND_IMM32; r.nb = 4; end
          end else r.mnem = 6'd31 + (rf - 3'd2);
        end
        8'hFF: begin
          r.has_mr = 1;
          if (rf == 0) r.mnem = 10;
          else if (rf == 1) r.mnem = 11;
          else if (rf == 2) r.mnem = 15;
          else if (rf == 4) r.mnem = 16;
          else r.unk = 1;
        end
        8'h68: begin r.mnem = 12; r.kind = KIND_IMM32; r.nb = 4; end
        8'h6A: begin r.mnem = 12; r.kind = KIND_IMM8; r.nb = 1; end
        8'h90: r.mnem = 17;
        8'hC3: r.mnem = 18;
        8'hCC: r.mnem = 19;
        8'hE0: begin r.mnem = 41; r.kind = KIND_IMM8; r.nb = 1; end
        8'hE1: begin r.mnem = 42; r.kind = KIND_IMM8; r.nb = 1; end
        8'hE2: begin r.mnem = 43; r.kind = KIND_TARGET; r.nb = 1; end
        8'hE3: begin r.mnem = 44; r.kind = KIND_IMM8; r.nb = 1; end
        8'hE8: begin r.mnem = 15; r.kind = KIND_TARGET; r.nb = 4; end
        8'hE9: begin r.mnem = 16; r.kind = KIND_TARGET; r.nb = 4; end
        8'hEB: begin r.mnem = 16; r.kind = KIND_IMM8; r.nb = 1; end
        8'hF0: r.mnem = 55;
        8'hF2: r.mnem = 56;
        default: r.unk = 1;
      endcase
    end
    return r;
  endfunction

  function automatic logic has_sib(logic [7:0] m);
    return m[7:6] != 2'd3 && m[2:0] == 3'd4;
  endfunction

  function automatic logic [2:0] disp_len(logic [7:0] m, logic [7:0] s);
    if (m[7:6] == 2'd3) return 0;
    if (m[7:6] == 2'd1) return 1;
    if (m[7:6] == 2'd2) return 4;
    if (m[2:0] == 3'd5) return 4;
    if (m[2:0] == 3'd4 && s[2:0] == 3'd5) return 4;
    return 0;
  endfunction

  function automatic insn_t build_insn(form_t f, logic [1:0] st);
    insn_t e;
    logic [2:0] ds;
    e = '0;
    ds = 0;
    e.start = istart;
    e.mnem = f.mnem;
    e.len = nbytes_taken;
    if (f.has_mr) begin
      e.modrm = mr;
      if (!f.unk) begin
        if (has_sib(mr)) e.sib = sb;
        ds = disp_len(mr, sb);
      end
    end
    if (ds == 1) e.disp = {{24{dacc[7]}}, dacc[7:0]};
    else if (ds == 4) e.disp = dacc;
    e.imm = iacc;
    if (f.kind == KIND_TARGET) begin
      if (f.nb == 4) e.imm = 32'(istart) + 32'd5 + iacc;
      else e.imm = 32'(istart) + 32'd2 + {{24{iacc[7]}}, iacc[7:0]};
    end
    e.layout = 5'((ds == 0 ? 0 : (ds == 1 ? 1 : 2)) * 6 + f.kind);
    e.regdst = f.regdst;
    e.embed = f.embed;
    e.st = st;
    e.last = 1'b1;
    return e;
  endfunction

  task automatic decode_byte(logic [7:0] b, logic eob);
    form_t f;
    logic done, need_disp, need_imm;
    logic [1:0] st;
    logic [2:0] ds, idx;
    insn_t e;
    done = 0; need_disp = 0; need_imm = 0; st = ST_OK;
    if (phase == PH_OPCODE) begin
      istart = offs; nbytes_taken = 1;
      op1 = b; op2 = 0; mr = 0; sb = 0; dacc = 0; iacc = 0; left = 0;
      if (b == OP_TWO_BYTE) phase = PH_SECOND;
      else if (b == OP_REP) phase = PH_AFTER_REP;
      else begin
        f = classify(b, 0, 0);
        if (f.unk) begin done = 1; st = ST_UNKNOWN; end
        else if (f.has_mr) phase = PH_MODRM;
        else need_imm = 1;
      end
    end else begin
      nbytes_taken = nbytes_taken + 1;
      case (phase)
        PH_SECOND: begin
          op2 = b;
          f = classify(op1, b, 0);
          if (!f.unk) phase = PH_MODRM;
          else if (!eob) begin done = 1; st = ST_UNKNOWN; end
        end
        PH_AFTER_REP: begin
          op2 = b;
          f = classify(op1, b, 0);
          done = 1; st = f.unk ? ST_UNKNOWN : ST_OK;
        end
        PH_MODRM: begin
          mr = b;
          f = classify(op1, op2, b);
          if (f.unk) begin done = 1; st = ST_UNKNOWN; end
          else if (has_sib(mr)) phase = PH_SIB;
          else need_disp = 1;
        end
        PH_SIB: begin sb = b; need_disp = 1; end
        PH_DISP: begin
          idx = disp_len(mr, sb) - left;
          dacc |= 32'(b) << (8 * idx[1:0]);
          left = left - 1;
          if (left == 0) need_imm = 1;
        end
        default: begin
          f = classify(op1, op2, mr);
          idx = f.nb - left;
          iacc |= 32'(b) << (8 * idx[1:0]);
          left = left - 1;
          if (left == 0) done = 1;
        end
      endcase
    end
    if (need_disp) begin
      ds = disp_len(mr, sb);
      if (ds != 0) begin left = ds; phase = PH_DISP; end
      else need_imm = 1;
    end
    if (need_imm) begin
      f = classify(op1, op2, mr);
      if (f.nb != 0) begin left = f.nb; phase = PH_IMM; end
      else done = 1;
    end
    if (done) begin
      f = classify(op1, op2, mr);
      if (op1 == OP_TWO_BYTE && f.unk) f.has_mr = 0;
      if (st == ST_UNKNOWN && op1 != OP_REP && op1 != OP_GROUP5) f.mnem = 0;
      e = build_insn(f, st);
      insn_q.push_back(e);
      if (st == ST_UNKNOWN) bad_count++; else insn_count++;
      phase = PH_OPCODE;
    end else if (eob && phase != PH_OPCODE) begin
      e = '0;
      e.start = istart; e.len = nbytes_taken; e.st = ST_INCOMPLETE; e.last = 1;
      insn_q.push_back(e);
      trunc_count++;
      phase = PH_OPCODE;
    end
    offs = eob ? 16'd0 : offs + 16'd1;
  endtask

  insn_t got, want;
  int    shown;

  always @(posedge clk) begin
    if (rst) begin
      phase = PH_OPCODE;
      op1 = 0; op2 = 0; mr = 0; sb = 0; dacc = 0; iacc = 0; left = 0;
      offs = 0; istart = 0; nbytes_taken = 0;
    end else begin
      // compare first: a result never belongs to the byte of the same edge
      if (out_valid && out_ready) begin
        got = '{start_offset, mnemonic, length, modrm_byte, sib_byte, displacement,
                immediate, operand_layout, reg_is_destination, embedded_field,
                status, last_of_run};
        if (insn_q.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("unexpected result transaction: %h", got);
          end
        end else begin
          want = insn_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("mismatch at %0t: expected %h", $time, want);
              $display("                  actual   %h", got);
            end
          end
        end
      end
      if (in_valid && in_ready) decode_byte(code_byte, end_of_buffer);
    end
    pending = insn_q.size();
  end

  initial begin
    fail_count = 0; pending = 0; shown = 0;
    insn_count = 0; bad_count = 0; trunc_count = 0;
  end
endmodule

FILE: test/x86_subset_instruction_predecoder_unit_tb.sv
// ----------------------------------------------------------------------------
// x86 predecoder testbench
// drives directed and random x86 code streams through the byte channel with
// varying idle and stall patterns; the checker verifies each result
// ----------------------------------------------------------------------------
module x86_subset_instruction_predecoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [7:0]  code_byte;
  logic        end_of_buffer;
  logic        out_valid, out_ready;
  logic [15:0] start_offset;
  logic [5:0]  mnemonic;
  logic [3:0]  length;
  logic [7:0]  modrm_byte, sib_byte;
  logic signed [31:0] displacement;
  logic [31:0] immediate;
  logic [4:0]  operand_layout;
  logic        reg_is_destination;
  logic [3:0]  embedded_field;
  logic [1:0]  status;
  logic        last_of_run;
  int          fail_count, pending, insn_count, bad_count, trunc_count;
  int          cycles, sent;
  int          send_idle, recv_stall;

  x86_subset_instruction_predecoder_unit u_top (.*);

  x86_subset_instruction_predecoder_unit_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls and the watchdog
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
    cycles++;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  byte unsigned code_q[$];
  bit           eob_q[$];

  task automatic send_byte(logic [7:0] b, logic eob);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    code_byte <= b;
    end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic put(logic [7:0] b);
    code_q.push_back(b);
  endtask

  // one random opcode, mostly from known families, with random operand bytes
  task automatic gen_insn();
    byte unsigned op, m;
    int k;
    k = $urandom_range(9);
    m = $urandom;
    case (k)
      0: begin op = $urandom_range(8'h3F); put(op); end
      1: begin
        op = 8'h80 + $urandom_range(13);
        put(op);
      end
      2: begin put(8'h0F); put(8'hB6 + ($urandom_range(1) ? 8 : 0) + $urandom_range(1)); end
      3: begin op = 8'hB0 + $urandom_range(15); put(op); end
      4: begin op = 8'hC0 + $urandom_range(63); put(op); end
      5: begin op = 8'h68 + 2 * $urandom_range(1); put(op); end
      6: begin put(8'hF3); put(8'hA4 + $urandom_range(1)); end
      7: begin op = 8'h70 + $urandom_range(15); put(op); end
      8: begin op = 8'hE0 + $urandom_range(11); put(op); end
      default: begin op = $urandom; put(op); end
    endcase
    // trailing bytes: modrm, sib, displacement and immediate are plenty random
    for (int i = 0; i < $urandom_range(10); i++) put($urandom);
  endtask

  task automatic flush_queue(bit close);
    while (code_q.size() > 0) begin
      send_byte(code_q.pop_front(), close && code_q.size() == 0);
    end
  endtask

  task automatic run_random(int n, int idle, int stall);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; ) begin
      gen_insn();
      i += code_q.size();
      flush_queue($urandom_range(15) == 0);
    end
  endtask

  initial begin
    cycles = 0; sent = 0;
    send_idle = 0; recv_stall = 0;
    in_valid = 0; code_byte = 0; end_of_buffer = 0; out_ready = 0;
    rst = 1;
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: extremes, each special case
    foreach (code_q[i]) ;
    put(8'h00); put(8'h04); put(8'h24); put(8'h05); put(8'hFF); put(8'hFF);
    put(8'h7F); put(8'h80);
    put(8'h0F); put(8'h01); put(8'h90);
    put(8'hFF); put(8'hF8);
    put(8'hF3); put(8'hAC);
    put(8'h05); put(8'h78); put(8'h56); put(8'h34); put(8'h12);
    put(8'hE8); put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF);
    flush_queue(0);
    put(8'hE2); put(8'h80); put(8'hD3); put(8'hC0); put(8'hD1); put(8'h00);
    put(8'hD6);
    flush_queue(0);
    put(8'h8B); put(8'h04); put(8'h25); put(8'h01); put(8'h02);
    flush_queue(1);
    put(8'h0F); put(8'h05); flush_queue(1);
    put(8'h0F); flush_queue(1);

    run_random(400, 0, 0);
    // hold off until all results are out
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    run_random(400, 71, 0);
    run_random(400, 0, 71);
    run_random(400, 22, 22);
    put(8'h90); flush_queue(1);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d code bytes: %0d decoded, %0d unknown, %0d truncated",
             sent, insn_count, bad_count, trunc_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
